[rtl/core/i2cm_pkg.sv]
// Shared types and constants for the I2C master bit engine.
// Holds the request and result payload structs, the sequencer state codes and phase limits.
// Depends on nothing.
package i2cm_pkg;

  localparam int unsigned PHASE_CNT_W_DEF = 16;
  localparam logic [15:0] PHASE_TICKS_RST = 16'd100;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [5:0] LAST_SHORT  = 6'd3;
  localparam logic [5:0] LAST_BYTE   = 6'd35;
  localparam logic [5:0] DATA_PHASES = 6'd32;
  localparam logic [5:0] ACK_PHASE   = 6'd33;
  localparam logic [1:0] Q_SAMPLE    = 2'd1;
  localparam logic [1:0] Q_HIGH_B    = 2'd2;
  localparam logic [1:0] Q_FIRST     = 2'd0;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_STOP  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_READ  = 5'b10000
  } state_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] opcode;
    logic [7:0] tx_byte;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
  } res_t;

endpackage

[rtl/core/i2cm_if.sv]
// Request and result channel interfaces of the I2C master bit engine.
// Each carries valid, ready and the payload fields; depends on nothing.
interface i2cm_req_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [1:0] opcode;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, cmd_valid, opcode, tx_byte, sda_in, input ready);
  modport sink (input valid, cmd_valid, opcode, tx_byte, sda_in, output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_received;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rx_byte, ack_received, input ready);
  modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                rx_byte, ack_received, output ready);
endinterface

[rtl/core/i2cm_seq.sv]
// Phase sequencer of the I2C master bit engine: command state, phase and tick counters,
// shift register and pin registers, advanced by one accepted request per cycle.
// Depends on i2cm_pkg.
module i2cm_seq #(
  parameter int unsigned PHASE_COUNTER_WIDTH = i2cm_pkg::PHASE_CNT_W_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               step,
  input  i2cm_pkg::cmd_t     cmd,
  output i2cm_pkg::res_t     res_next
);
  import i2cm_pkg::*;

  localparam int unsigned W  = PHASE_COUNTER_WIDTH;
  localparam int unsigned CW = (W > 16) ? W : 16;

  logic [15:0]  phase_ticks;
  state_t       state, state_next;
  logic [5:0]   phase, phase_next;
  logic [W-1:0] tick, tick_next;
  logic [7:0]   shift, shift_next;
  logic         ack, ack_next;
  logic         scl, scl_next;
  logic         sda, sda_next;
  logic         drive, drive_next;
  logic [7:0]   rx_hold, rx_hold_next;
  logic         done;

  logic [CW-1:0] ticks_m1;
  logic [W-1:0]  tick_last;

  always_comb begin
    ticks_m1 = (phase_ticks == 16'd0) ? '0 : CW'(phase_ticks) - CW'(1);
    tick_last = ((ticks_m1 >> W) != '0) ? '1 : W'(ticks_m1);
  end

  always_comb begin
    state_t     st_a;
    logic [1:0] q;
    logic       hi;
    logic       is_write;
    logic       is_read;
    st_a = state;
    phase_next = phase;
    tick_next = tick;
    shift_next = shift;
    ack_next = ack;
    scl_next = scl;
    sda_next = sda;
    drive_next = drive;
    rx_hold_next = rx_hold;
    done = 1'b0;
    if (state == ST_IDLE && cmd.cmd_valid) begin
      unique case (cmd.opcode)
        OP_START: st_a = ST_START;
        OP_STOP:  st_a = ST_STOP;
        OP_WRITE: st_a = ST_WRITE;
        OP_READ:  st_a = ST_READ;
        default:  st_a = ST_IDLE;
      endcase
      phase_next = '0;
      tick_next = '0;
      if (cmd.opcode == OP_WRITE) begin
        shift_next = cmd.tx_byte;
      end else if (cmd.opcode == OP_READ) begin
        shift_next = '0;
      end
    end
    state_next = st_a;
    q = phase_next[1:0];
    hi = (q == Q_SAMPLE) || (q == Q_HIGH_B);
    is_write = (st_a == ST_WRITE);
    is_read = (st_a == ST_READ);

    unique case (st_a)
      ST_START: begin
        scl_next = (phase_next != LAST_SHORT);
        sda_next = (phase_next < 6'd2);
        drive_next = 1'b1;
      end
      ST_STOP: begin
        scl_next = (phase_next != 6'd0);
        sda_next = (phase_next >= 6'd2);
        drive_next = 1'b1;
      end
      ST_WRITE: begin
        scl_next = hi;
        if (phase_next < DATA_PHASES) begin
          sda_next = shift_next[3'd7 - phase_next[4:2]];
          drive_next = 1'b1;
        end else begin
          sda_next = 1'b1;
          drive_next = 1'b0;
        end
      end
      ST_READ: begin
        scl_next = hi;
        if (phase_next < DATA_PHASES || q == Q_FIRST) begin
          sda_next = 1'b1;
          drive_next = 1'b0;
        end else begin
          sda_next = 1'b0;
          drive_next = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (st_a != ST_IDLE) begin
      if (tick_next >= tick_last) begin
        if (q == Q_SAMPLE) begin
          if (is_write && phase_next == ACK_PHASE) begin
            ack_next = !cmd.sda_in;
          end else if (is_read && phase_next < DATA_PHASES) begin
            shift_next = {shift_next[6:0], cmd.sda_in};
          end
        end
        tick_next = '0;
        if (phase_next >= ((is_write || is_read) ? LAST_BYTE : LAST_SHORT)) begin
          if (is_read) begin
            rx_hold_next = shift_next;
          end
          state_next = ST_IDLE;
          phase_next = '0;
          done = 1'b1;
        end else begin
          phase_next = phase_next + 6'd1;
        end
      end else begin
        tick_next = tick_next + W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RST;
      state <= ST_IDLE;
      phase <= '0;
      tick <= '0;
      shift <= '0;
      ack <= 1'b0;
      scl <= 1'b1;
      sda <= 1'b1;
      drive <= 1'b1;
      rx_hold <= '0;
    end else begin
      if (cfg_we) begin
        phase_ticks <= cfg_wdata;
      end
      if (step) begin
        state <= state_next;
        phase <= phase_next;
        tick <= tick_next;
        shift <= shift_next;
        ack <= ack_next;
        scl <= scl_next;
        sda <= sda_next;
        drive <= drive_next;
        rx_hold <= rx_hold_next;
      end
    end
  end

  always_comb begin
    res_next.scl_level = scl_next;
    res_next.sda_level = sda_next;
    res_next.sda_drive = drive_next;
    res_next.busy_res = (state_next != ST_IDLE);
    res_next.done_res = done;
    res_next.rx_byte = rx_hold_next;
    res_next.ack_received = ack_next;
  end

`ifndef NO_ASSERTIONS
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= LAST_BYTE)
    else $error("phase index beyond the last ack phase");
  a_short_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_START || state == ST_STOP) |-> phase <= LAST_SHORT)
    else $error("start or stop sequence runs past its last phase");
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> (phase == '0 && tick == '0))
    else $error("counters not cleared while idle");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (step && done) |=> state == ST_IDLE)
    else $error("command finished but sequencer did not return to idle");
`endif

endmodule

[rtl/core/i2cm_out_reg.sv]
// Result register of the I2C master bit engine: holds one result until the sink takes it
// and frees the request side as soon as it is empty or being drained. Depends on i2cm_pkg.
module i2cm_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load_valid,
  output logic           load_ready,
  input  i2cm_pkg::res_t load_data,
  i2cm_res_if.source     res
);
  import i2cm_pkg::*;

  logic full;
  res_t data;

  assign load_ready = !full || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load_ready) begin
      full <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      data <= load_data;
    end
  end

  assign res.valid = full;
  assign res.scl_level = data.scl_level;
  assign res.sda_level = data.sda_level;
  assign res.sda_drive = data.sda_drive;
  assign res.busy_res = data.busy_res;
  assign res.done_res = data.done_res;
  assign res.rx_byte = data.rx_byte;
  assign res.ack_received = data.ack_received;

endmodule

[rtl/core/i2c_master_bit_engine.sv]
// I2C master bit engine, top level.
// Uses i2cm_pkg, the i2cm_req_if and i2cm_res_if interfaces, i2cm_seq and i2cm_out_reg.
//
// Each request on the req channel is one tick of the bus timing: an optional command
// (start, stop, write byte, read byte with ack) and the sampled SDA level. Every request
// yields exactly one result on the res channel with the SCL and SDA pin levels, busy,
// a one-tick done pulse, the last received byte and the last ack status.
// A request is accepted in every cycle while the result register is empty or being
// drained, so one request per cycle is sustained and each result appears in the cycle
// after its request. If the result sink stalls, one result is held and req.ready drops
// until it is taken; no result is lost or repeated.
// Commands arriving while a command is in progress are ignored.
// The phase_ticks register (reset 100) is written through cfg_we and cfg_wdata and
// sets the length of each quarter-bit phase in requests.
// Synchronous reset returns the engine to idle with SCL and SDA driven high and the
// result register empty.
module i2c_master_bit_engine #(
  parameter int unsigned PHASE_COUNTER_WIDTH = i2cm_pkg::PHASE_CNT_W_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  i2cm_req_if.sink    req,
  i2cm_res_if.source  res
);
  import i2cm_pkg::*;

  cmd_t cmd;
  res_t res_next;
  logic load_ready;
  logic step;

  assign cmd.cmd_valid = req.cmd_valid;
  assign cmd.opcode = req.opcode;
  assign cmd.tx_byte = req.tx_byte;
  assign cmd.sda_in = req.sda_in;

  assign req.ready = load_ready;
  assign step = req.valid && load_ready;

  i2cm_seq #(
    .PHASE_COUNTER_WIDTH(PHASE_COUNTER_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .step     (step),
    .cmd      (cmd),
    .res_next (res_next)
  );

  i2cm_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load_valid(req.valid),
    .load_ready(load_ready),
    .load_data (res_next),
    .res       (res)
  );

endmodule
